/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared constants, codes and helpers
// Sizes, tag encoding, status codes and register indexes for the buddy
// block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MAX_ORDER    = 10;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned NORD         = MAX_ORDER + 1;
  localparam int unsigned NBLK         = 1 << MAX_ORDER;
  localparam int unsigned BLK_W        = MAX_ORDER;
  localparam int unsigned LINK_W       = MAX_ORDER + 1;
  localparam int unsigned ORD_W        = 4;
  localparam int unsigned TAG_W        = 6;
  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned UNITS_W      = 22;
  localparam int unsigned IORD_W       = 5;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 4;
  localparam int unsigned LG_MIN       = 4;
  localparam int unsigned LG_MAX       = 14;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NBLK);

  // block tag kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_USED = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASIC_LOG2 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ORDERS     = CFG_IDX_W'(1);

  typedef logic [LINK_W-1:0] heads_t [NORD];

  function automatic logic [TAG_W-1:0] mk_tag(logic [1:0] kind, logic [ORD_W-1:0] ord);
    mk_tag = {kind, ord};
  endfunction

  // smallest i with 2^i >= units
  function automatic logic [IORD_W-1:0] units_order(logic [UNITS_W-1:0] units);
    logic [UNITS_W-1:0] v;
    logic [IORD_W-1:0]  r;
    v = units - UNITS_W'(1);
    r = '0;
    if (units > UNITS_W'(1)) begin
      for (int k = 0; k < UNITS_W; k++) begin
        if (v[k]) r = IORD_W'(k + 1);
      end
    end
    units_order = r;
  endfunction

  // store after reset: only the top order holds block zero
  function automatic heads_t heads_init(logic [ORD_W-1:0] top);
    heads_t h;
    for (int k = 0; k < NORD; k++) begin
      h[k] = (ORD_W'(k) == top) ? '0 : NIL;
    end
    heads_init = h;
  endfunction

endpackage

/* src/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram: generic synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/buddy_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_top: binary buddy allocator
// Sequencer over a tag RAM and a link RAM with per-order LIFO free lists.
// ----------------------------------------------------------------------------
// One request at a time. An allocate holds busy_o through the units, order,
// find and pop steps and a split step per split level. A free holds it
// through the check and tag steps, a merge check per level below the top,
// and a walk of the free list to unlink each free buddy, where each walk
// step waits on a link RAM read, then a push. The result appears for one
// cycle on done_o and cannot be stalled. After reset and after each write to
// a known register, a clearing pass sweeps the tag RAM with busy_o high;
// configuration writes are still taken during it. In idle a configuration
// write is held off while start_i is high.
module buddy_block_allocator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               op_i,
  input  logic [bba_pkg::ADDR_W-1:0]         request_length_i,
  input  logic [bba_pkg::ADDR_W-1:0]         free_address_i,
  output logic                               done_o,
  output logic [bba_pkg::ADDR_W-1:0]         user_address_o,
  output logic [bba_pkg::ORD_W-1:0]          granted_order_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CLEAR   = 14'b00000000000010,
    S_A_UNITS = 14'b00000000000100,
    S_A_ORDER = 14'b00000000001000,
    S_A_FIND  = 14'b00000000010000,
    S_A_POP   = 14'b00000000100000,
    S_A_SPLIT = 14'b00000001000000,
    S_F_CHECK = 14'b00000010000000,
    S_F_TAG   = 14'b00000100000000,
    S_M_CHK   = 14'b00001000000000,
    S_M_TAG   = 14'b00010000000000,
    S_U_CHK   = 14'b00100000000000,
    S_U_ADV   = 14'b01000000000000,
    S_F_PUSH  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [bba_pkg::CFG_DATA_W-1:0] lg_cfg_q, lg_cfg_d, ord_cfg_q, ord_cfg_d;
  bba_pkg::heads_t                heads_q, heads_d;
  logic [bba_pkg::BLK_W-1:0]      clr_q, clr_d;
  logic                           op_q, op_d;
  logic [bba_pkg::ADDR_W-1:0]     len_q, len_d, faddr_q, faddr_d;
  logic [bba_pkg::UNITS_W-1:0]    units_q, units_d;
  logic [bba_pkg::IORD_W-1:0]     iord_q, iord_d;
  logic [bba_pkg::ORD_W-1:0]      k_q, k_d, ford_q, ford_d;
  logic [bba_pkg::BLK_W-1:0]      b_q, b_d, bud_q, bud_d;
  logic [bba_pkg::LINK_W-1:0]     cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic                           done_q, done_d;
  logic [bba_pkg::ADDR_W-1:0]     ua_q, ua_d;
  logic [bba_pkg::ORD_W-1:0]      ord_q, ord_d;
  logic [1:0]                     st_q, st_d;

  logic                           tag_we, link_we;
  logic [bba_pkg::BLK_W-1:0]      tag_wa, tag_ra, link_wa, link_ra;
  logic [bba_pkg::TAG_W-1:0]      tag_wd, tag_rd;
  logic [bba_pkg::LINK_W-1:0]     link_wd, link_rd;

  logic [bba_pkg::ORD_W-1:0]      lg_eff, ord_eff, top;
  logic                           cfg_fire, cfg_known;
  logic [bba_pkg::ORD_W-1:0]      jsel, kdec;
  logic                           jfound;
  logic [bba_pkg::ADDR_W:0]       req;
  logic [bba_pkg::ADDR_W+1:0]     usum, umask;
  logic [bba_pkg::ADDR_W-1:0]     amask, off, bfull;
  logic                           free_ok;
  logic [bba_pkg::BLK_W-1:0]      bmin;
  logic [bba_pkg::ADDR_W:0]       ua_sum;

  // tag and link stores
  bba_ram #(.WIDTH(bba_pkg::TAG_W), .DEPTH(bba_pkg::NBLK)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_wa),
    .wdata_i (tag_wd),
    .raddr_i (tag_ra),
    .rdata_o (tag_rd)
  );

  bba_ram #(.WIDTH(bba_pkg::LINK_W), .DEPTH(bba_pkg::NBLK)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .raddr_i (link_ra),
    .rdata_o (link_rd)
  );

  // saturate the registers
  always_comb begin
    if (lg_cfg_q < bba_pkg::ORD_W'(bba_pkg::LG_MIN)) lg_eff = bba_pkg::ORD_W'(bba_pkg::LG_MIN);
    else if (lg_cfg_q > bba_pkg::ORD_W'(bba_pkg::LG_MAX)) lg_eff = bba_pkg::ORD_W'(bba_pkg::LG_MAX);
    else lg_eff = lg_cfg_q;
    if (ord_cfg_q == '0) ord_eff = bba_pkg::ORD_W'(1);
    else if (ord_cfg_q > bba_pkg::ORD_W'(bba_pkg::NORD)) ord_eff = bba_pkg::ORD_W'(bba_pkg::NORD);
    else ord_eff = ord_cfg_q;
    top = ord_eff - bba_pkg::ORD_W'(1);
  end

  // hold off a register write while a request is being taken
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = ((state_q == S_IDLE) && !start_i) || (state_q == S_CLEAR);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_known   = (cfg_index_i == bba_pkg::CFG_BASIC_LOG2) ||
                       (cfg_index_i == bba_pkg::CFG_ORDERS);

  // find the smallest non-empty list at or above the wanted order
  always_comb begin
    jsel   = '0;
    jfound = 1'b0;
    for (int k = bba_pkg::NORD - 1; k >= 0; k--) begin
      if ((bba_pkg::IORD_W'(k) >= iord_q) && (bba_pkg::ORD_W'(k) <= top) &&
          !heads_q[k][bba_pkg::LINK_W-1]) begin
        jsel   = bba_pkg::ORD_W'(k);
        jfound = 1'b1;
      end
    end
  end

  // address arithmetic
  always_comb begin
    req    = {1'b0, len_q} + (bba_pkg::ADDR_W+1)'(bba_pkg::HEADER_BYTES);
    umask  = ((bba_pkg::ADDR_W+2)'(1) << lg_eff) - (bba_pkg::ADDR_W+2)'(1);
    usum   = {1'b0, req} + umask;
    amask  = umask[bba_pkg::ADDR_W-1:0];
    off    = faddr_q - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
    bfull  = off >> lg_eff;
    free_ok = (faddr_q >= bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES)) &&
              ((off & amask) == '0) &&
              (bfull < (bba_pkg::ADDR_W'(1) << top));
    bmin   = (bud_q < b_q) ? bud_q : b_q;
    kdec   = k_q - bba_pkg::ORD_W'(1);
    ua_sum = {1'b0, (bba_pkg::ADDR_W'(b_q) << lg_eff)} +
             (bba_pkg::ADDR_W+1)'(bba_pkg::HEADER_BYTES);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    lg_cfg_d  = lg_cfg_q;
    ord_cfg_d = ord_cfg_q;
    heads_d   = heads_q;
    clr_d     = clr_q;
    op_d      = op_q;
    len_d     = len_q;
    faddr_d   = faddr_q;
    units_d   = units_q;
    iord_d    = iord_q;
    k_d       = k_q;
    ford_d    = ford_q;
    b_d       = b_q;
    bud_d     = bud_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    steps_d   = steps_q;
    done_d    = 1'b0;
    ua_d      = ua_q;
    ord_d     = ord_q;
    st_d      = st_q;
    tag_we    = 1'b0;
    tag_wa    = b_q;
    tag_wd    = '0;
    tag_ra    = b_q;
    link_we   = 1'b0;
    link_wa   = b_q;
    link_wd   = heads_q[k_q];
    link_ra   = b_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          len_d   = request_length_i;
          faddr_d = free_address_i;
          state_d = (op_i == bba_pkg::OP_FREE) ? S_F_CHECK : S_A_UNITS;
        end
      end
      // sweep the tag store and seed the top block
      S_CLEAR: begin
        tag_we  = 1'b1;
        tag_wa  = clr_q;
        tag_wd  = (clr_q == '0) ? bba_pkg::mk_tag(bba_pkg::KIND_FREE, top) : '0;
        link_we = (clr_q == '0);
        link_wa = '0;
        link_wd = bba_pkg::NIL;
        heads_d = bba_pkg::heads_init(top);
        clr_d   = clr_q + bba_pkg::BLK_W'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_A_UNITS: begin
        units_d = bba_pkg::UNITS_W'(usum >> lg_eff);
        state_d = S_A_ORDER;
      end
      S_A_ORDER: begin
        iord_d  = bba_pkg::units_order(units_q);
        state_d = S_A_FIND;
      end
      S_A_FIND: begin
        if (iord_q > {1'b0, top}) begin
          done_d = 1'b1; ua_d = '0; ord_d = '0; st_d = bba_pkg::ST_TOO_LARGE;
          state_d = S_IDLE;
        end else if (!jfound) begin
          done_d = 1'b1; ua_d = '0; ord_d = '0; st_d = bba_pkg::ST_NO_BLOCK;
          state_d = S_IDLE;
        end else begin
          b_d     = heads_q[jsel][bba_pkg::BLK_W-1:0];
          k_d     = jsel;
          link_ra = heads_q[jsel][bba_pkg::BLK_W-1:0];
          state_d = S_A_POP;
        end
      end
      // drop the popped block from its list
      S_A_POP: begin
        heads_d[k_q] = link_rd;
        state_d      = S_A_SPLIT;
      end
      // push upper buddies one order at a time, then mark the block used
      S_A_SPLIT: begin
        if ({1'b0, k_q} > iord_q) begin
          link_we       = 1'b1;
          link_wa       = b_q + (bba_pkg::BLK_W'(1) << kdec);
          link_wd       = heads_q[kdec];
          heads_d[kdec] = {1'b0, b_q + (bba_pkg::BLK_W'(1) << kdec)};
          tag_we        = 1'b1;
          tag_wa        = b_q + (bba_pkg::BLK_W'(1) << kdec);
          tag_wd        = bba_pkg::mk_tag(bba_pkg::KIND_FREE, kdec);
          k_d           = kdec;
        end else begin
          tag_we  = 1'b1;
          tag_wa  = b_q;
          tag_wd  = bba_pkg::mk_tag(bba_pkg::KIND_USED, iord_q[bba_pkg::ORD_W-1:0]);
          done_d  = 1'b1;
          ua_d    = ua_sum[bba_pkg::ADDR_W-1:0];
          ord_d   = iord_q[bba_pkg::ORD_W-1:0];
          st_d    = bba_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_F_CHECK: begin
        if (!free_ok) begin
          done_d = 1'b1; ua_d = '0; ord_d = '0; st_d = bba_pkg::ST_BAD_FREE;
          state_d = S_IDLE;
        end else begin
          b_d     = bfull[bba_pkg::BLK_W-1:0];
          tag_ra  = bfull[bba_pkg::BLK_W-1:0];
          state_d = S_F_TAG;
        end
      end
      S_F_TAG: begin
        if (tag_rd[bba_pkg::TAG_W-1:bba_pkg::ORD_W] != bba_pkg::KIND_USED) begin
          done_d = 1'b1; ua_d = '0; ord_d = '0; st_d = bba_pkg::ST_BAD_FREE;
          state_d = S_IDLE;
        end else begin
          k_d     = tag_rd[bba_pkg::ORD_W-1:0];
          ford_d  = tag_rd[bba_pkg::ORD_W-1:0];
          tag_we  = 1'b1;
          tag_wa  = b_q;
          tag_wd  = bba_pkg::mk_tag(bba_pkg::KIND_NONE, '0);
          state_d = S_M_CHK;
        end
      end
      // read the buddy's tag while below the top order
      S_M_CHK: begin
        if (k_q < top) begin
          bud_d   = b_q ^ (bba_pkg::BLK_W'(1) << k_q);
          tag_ra  = b_q ^ (bba_pkg::BLK_W'(1) << k_q);
          state_d = S_M_TAG;
        end else begin
          state_d = S_F_PUSH;
        end
      end
      S_M_TAG: begin
        if (tag_rd != bba_pkg::mk_tag(bba_pkg::KIND_FREE, k_q)) begin
          state_d = S_F_PUSH;
        end else begin
          cur_d   = heads_q[k_q];
          prev_d  = bba_pkg::NIL;
          steps_d = '0;
          state_d = S_U_CHK;
        end
      end
      // walk the list: end of list or step limit leaves it unchanged
      S_U_CHK: begin
        if (cur_q[bba_pkg::LINK_W-1] || steps_q[bba_pkg::LINK_W-1]) begin
          tag_we  = 1'b1;
          tag_wa  = bud_q;
          tag_wd  = bba_pkg::mk_tag(bba_pkg::KIND_NONE, '0);
          b_d     = bmin;
          k_d     = k_q + bba_pkg::ORD_W'(1);
          state_d = S_M_CHK;
        end else begin
          link_ra = cur_q[bba_pkg::BLK_W-1:0];
          state_d = S_U_ADV;
        end
      end
      S_U_ADV: begin
        if (cur_q[bba_pkg::BLK_W-1:0] == bud_q) begin
          if (prev_q == bba_pkg::NIL) begin
            heads_d[k_q] = link_rd;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q[bba_pkg::BLK_W-1:0];
            link_wd = link_rd;
          end
          tag_we  = 1'b1;
          tag_wa  = bud_q;
          tag_wd  = bba_pkg::mk_tag(bba_pkg::KIND_NONE, '0);
          b_d     = bmin;
          k_d     = k_q + bba_pkg::ORD_W'(1);
          state_d = S_M_CHK;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          steps_d = steps_q + bba_pkg::LINK_W'(1);
          state_d = S_U_CHK;
        end
      end
      // push the merged block
      S_F_PUSH: begin
        link_we      = 1'b1;
        link_wa      = b_q;
        link_wd      = heads_q[k_q];
        heads_d[k_q] = {1'b0, b_q};
        tag_we       = 1'b1;
        tag_wa       = b_q;
        tag_wd       = bba_pkg::mk_tag(bba_pkg::KIND_FREE, k_q);
        done_d       = 1'b1;
        ua_d         = '0;
        ord_d        = ford_q;
        st_d         = bba_pkg::ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a write to a known register restarts the store
    if (cfg_fire) begin
      if (cfg_index_i == bba_pkg::CFG_BASIC_LOG2) lg_cfg_d = cfg_data_i;
      if (cfg_index_i == bba_pkg::CFG_ORDERS) ord_cfg_d = cfg_data_i;
      if (cfg_known) begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      lg_cfg_q  <= bba_pkg::CFG_DATA_W'(6);
      ord_cfg_q <= bba_pkg::CFG_DATA_W'(11);
      heads_q   <= bba_pkg::heads_init(bba_pkg::ORD_W'(bba_pkg::MAX_ORDER));
      clr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      lg_cfg_q  <= lg_cfg_d;
      ord_cfg_q <= ord_cfg_d;
      heads_q   <= heads_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    len_q   <= len_d;
    faddr_q <= faddr_d;
    units_q <= units_d;
    iord_q  <= iord_d;
    k_q     <= k_d;
    ford_q  <= ford_d;
    b_q     <= b_d;
    bud_q   <= bud_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    ua_q    <= ua_d;
    ord_q   <= ord_d;
    st_q    <= st_d;
  end

  assign done_o          = done_q;
  assign user_address_o  = ua_q;
  assign granted_order_o = ord_q;
  assign status_o        = st_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && cfg_known) |=> (state_q == S_CLEAR))
    else $error("register write did not restart the store");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cfg_fire) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bba_pkg::ST_OK) |-> (user_address_o == '0 && granted_order_o == '0))
    else $error("error result carries address or order");

  a_ord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bba_pkg::ST_OK) |->
      (granted_order_o <= bba_pkg::ORD_W'(bba_pkg::MAX_ORDER)))
    else $error("granted order out of range");

endmodule
